// ===== sv/pavm_pkg.sv =====
// Shared types, constants and the sine table function of the polyphonic voice mixer.
package pavm_pkg;

	localparam int PHASE_W    = 24;
	localparam int SINE_DEPTH = 256;
	localparam int SINE_AW    = 8;
	localparam int LEN_W      = 20;
	localparam int LVL_W      = 16;
	localparam int GAIN_W     = 16;
	localparam int AMP_W      = 16;
	localparam int CMD_W      = 2;
	localparam int VIDX_W     = 3;
	localparam int WSEL_W     = 2;
	localparam int SAMPLE_W   = 16;
	localparam int ACT_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int WAVE_W     = 17;
	localparam int V_W        = 18;
	localparam int ENV_W      = 17;
	localparam int C_W        = 19;
	localparam int Q_W        = 16;
	localparam int MB_W       = 17;
	localparam int EPROD_W    = LEN_W + MB_W;
	localparam int DIV_CNT_W  = 4;
	localparam int MIX_W      = 32;
	localparam int RES_W      = 48;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_NOTE_ON  = 2'd1,
		CMD_NOTE_OFF = 2'd2,
		CMD_NONE     = 2'd3
	} cmd_t;

	typedef enum logic [WSEL_W-1:0] {
		WV_SINE   = 2'd0,
		WV_SQUARE = 2'd1,
		WV_TRI    = 2'd2,
		WV_SAW    = 2'd3
	} wave_sel_t;

	typedef enum logic [2:0] {
		ST_DONE    = 3'd0,
		ST_ATTACK  = 3'd1,
		ST_DECAY   = 3'd2,
		ST_SUSTAIN = 3'd3,
		ST_RELEASE = 3'd4
	} env_stage_t;

	typedef enum logic [2:0] {
		LV_QUO  = 3'd0,
		LV_UP   = 3'd1,
		LV_DOWN = 3'd2,
		LV_REL  = 3'd3,
		LV_FIX  = 3'd4
	} lvl_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ATTACK  = 3'd0,
		CFG_DECAY   = 3'd1,
		CFG_SUSTAIN = 3'd2,
		CFG_RELEASE = 3'd3,
		CFG_GAIN    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic start_tick;
		logic note_apply;
		logic scan;
		logic next_voice;
		logic vmul;
		logic emul;
		logic dinit;
		logic dstep;
		logic level;
		logic acc;
		logic mix1;
		logic mix2;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic voice_on;
		logic last_voice;
		logic need_div;
		logic div_last;
	} dp_stat_t;

	// Quarter-wave odd series in Q30, evaluated at elaboration only.
	function automatic logic signed [WAVE_W-1:0] sine_q15(input int k);
		longint unsigned u;
		longint unsigned quad;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint unsigned s;
		longint unsigned v;
		logic signed [WAVE_W-1:0] vs;
		u = (64'(k) << 32) / SINE_DEPTH;
		quad = (u >> 30) & 64'd3;
		r = u & 64'd1073741823;
		if (quad[0])
			r = 64'd1073741824 - r;
		x = (r * 64'd1686629713) >> 30;
		x2 = (x * x) >> 30;
		t = 64'd1073741824;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 110;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 72;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
		t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
		s = (x * t) >> 30;
		v = (s * 64'd32768 + 64'd536870912) >> 30;
		vs = WAVE_W'(v);
		return (quad >= 64'd2) ? -vs : vs;
	endfunction

endpackage

// ===== sv/pavm_ctrl.sv =====
// Sequencing state machine of the polyphonic voice mixer.
module pavm_ctrl import pavm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [CMD_W-1:0] cmd,
	output logic             out_valid,
	input  logic             out_stall,
	output dp_cmd_t          ctl,
	input  dp_stat_t         stat
);

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_SCAN  = 11'b000_0000_0010,
		S_VMUL  = 11'b000_0000_0100,
		S_EMUL  = 11'b000_0000_1000,
		S_DINIT = 11'b000_0001_0000,
		S_DIV   = 11'b000_0010_0000,
		S_LEVEL = 11'b000_0100_0000,
		S_ACC   = 11'b000_1000_0000,
		S_MIX1  = 11'b001_0000_0000,
		S_MIX2  = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (cmd == CMD_TICK) begin
						ctl.start_tick = 1'b1;
						state_d = S_SCAN;
					end else begin
						ctl.note_apply = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (stat.voice_on) begin
					ctl.scan = 1'b1;
					state_d = S_VMUL;
				end else if (stat.last_voice) begin
					state_d = S_MIX1;
				end else begin
					ctl.next_voice = 1'b1;
				end
			end
			S_VMUL: begin
				ctl.vmul = 1'b1;
				state_d = stat.need_div ? S_EMUL : S_LEVEL;
			end
			S_EMUL: begin
				ctl.emul = 1'b1;
				state_d = S_DINIT;
			end
			S_DINIT: begin
				ctl.dinit = 1'b1;
				state_d = S_DIV;
			end
			S_DIV: begin
				ctl.dstep = 1'b1;
				if (stat.div_last)
					state_d = S_LEVEL;
			end
			S_LEVEL: begin
				ctl.level = 1'b1;
				state_d = S_ACC;
			end
			S_ACC: begin
				ctl.acc = 1'b1;
				if (stat.last_voice) begin
					state_d = S_MIX1;
				end else begin
					ctl.next_voice = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_MIX1: begin
				ctl.mix1 = 1'b1;
				state_d = S_MIX2;
			end
			S_MIX2: begin
				ctl.mix2 = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					ctl.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/pavm_dp.sv =====
// Voice store, wave and envelope arithmetic, divider and mixer of the voice mixer.
module pavm_dp import pavm_pkg::*; #(
	parameter int VOICES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               ctl,
	output dp_stat_t              stat,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [VIDX_W-1:0]     voice_index,
	input  logic [PHASE_W-1:0]    phase_step,
	input  logic [WSEL_W-1:0]     waveform,
	input  logic [AMP_W-1:0]      amplitude,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [ACT_W-1:0]      active_count
);

	localparam int VI_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int SUM_W  = C_W + $clog2(VOICES + 1);
	localparam int MIXP_W = SUM_W + GAIN_W + 1;
	localparam logic signed [MIXP_W-1:0] MIX_HI = MIXP_W'(64'sd1073741824);
	localparam logic signed [MIXP_W-1:0] MIX_LO = -MIX_HI;
	localparam logic signed [WAVE_W-1:0] W_POS  = 17'sd32768;
	localparam logic signed [WAVE_W-1:0] W_NEG  = -17'sd32768;

	// Configuration registers.
	logic [LEN_W-1:0]  attack_len_q, decay_len_q, release_len_q;
	logic [LVL_W-1:0]  sustain_lvl_q;
	logic [GAIN_W-1:0] master_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= 20'd441;
			decay_len_q   <= 20'd4410;
			sustain_lvl_q <= 16'd22938;
			release_len_q <= 20'd8820;
			master_gain_q <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ATTACK:  attack_len_q  <= cfg_data;
				CFG_DECAY:   decay_len_q   <= cfg_data;
				CFG_SUSTAIN: sustain_lvl_q <= cfg_data[LVL_W-1:0];
				CFG_RELEASE: release_len_q <= cfg_data;
				CFG_GAIN:    master_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Voice store.
	logic             on_q    [VOICES];
	env_stage_t       stage_q [VOICES];
	logic [PHASE_W-1:0] phase_q [VOICES];
	logic [PHASE_W-1:0] step_q  [VOICES];
	logic [AMP_W-1:0]   amp_q   [VOICES];
	logic [WSEL_W-1:0]  wsel_q  [VOICES];
	logic [LEN_W-1:0]   count_q [VOICES];

	logic [VI_W-1:0] idx_q;
	logic            note_ok;
	logic [VI_W-1:0] note_idx;

	assign note_ok  = (32'(voice_index) < 32'(VOICES));
	assign note_idx = VI_W'(voice_index);

	// Registers of the voice in flight.
	env_stage_t         ns_q;
	logic [LEN_W-1:0]   nc_q;
	logic               need_q;
	logic [LEN_W-1:0]   ma_q;
	logic [MB_W-1:0]    mb_q;
	logic [LEN_W-1:0]   den_q;
	lvl_mode_t          mode_q;
	logic [ENV_W-1:0]   fix_q;
	logic signed [WAVE_W-1:0] wave_q;
	logic [AMP_W-1:0]   vamp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VOICES; i++) begin
				on_q[i]    <= 1'b0;
				stage_q[i] <= ST_DONE;
			end
		end else begin
			if (ctl.note_apply && note_ok) begin
				if (cmd == CMD_NOTE_ON) begin
					on_q[note_idx]    <= 1'b1;
					stage_q[note_idx] <= ST_ATTACK;
				end else if (cmd == CMD_NOTE_OFF && stage_q[note_idx] != ST_RELEASE &&
						stage_q[note_idx] != ST_DONE) begin
					stage_q[note_idx] <= ST_RELEASE;
				end
			end
			if (ctl.acc) begin
				stage_q[idx_q] <= ns_q;
				on_q[idx_q]    <= (ns_q != ST_DONE);
			end
		end
	end

	logic [PHASE_W-1:0] cur_phase;
	env_stage_t         cur_stage;
	logic [LEN_W-1:0]   cur_count;

	assign cur_phase = phase_q[idx_q];
	assign cur_stage = stage_q[idx_q];
	assign cur_count = count_q[idx_q];

	always_ff @(posedge clk) begin
		if (ctl.note_apply && note_ok) begin
			if (cmd == CMD_NOTE_ON) begin
				phase_q[note_idx] <= '0;
				step_q[note_idx]  <= phase_step;
				amp_q[note_idx]   <= amplitude;
				wsel_q[note_idx]  <= waveform;
				count_q[note_idx] <= '0;
			end else if (cmd == CMD_NOTE_OFF && stage_q[note_idx] != ST_RELEASE &&
					stage_q[note_idx] != ST_DONE) begin
				count_q[note_idx] <= '0;
			end
		end
		if (ctl.scan)
			phase_q[idx_q] <= cur_phase + step_q[idx_q];
		if (ctl.acc)
			count_q[idx_q] <= nc_q;
	end

	// Wave generation from the old phase.
	logic signed [WAVE_W-1:0] sine_rom [SINE_DEPTH];

	for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine
		localparam logic signed [WAVE_W-1:0] SV = sine_q15(g);
		assign sine_rom[g] = SV;
	end

	logic [16:0]              p4;
	logic [15:0]              p16;
	logic signed [18:0]       tri_mid;
	logic signed [WAVE_W-1:0] wave_d;

	assign p4      = cur_phase[PHASE_W-1 -: 17];
	assign p16     = cur_phase[PHASE_W-1 -: 16];
	assign tri_mid = 19'sd65536 - $signed({2'b00, p4});

	always_comb begin
		unique case (wave_sel_t'(wsel_q[idx_q]))
			WV_SINE:   wave_d = sine_rom[cur_phase[PHASE_W-1 -: SINE_AW]];
			WV_SQUARE: wave_d = cur_phase[PHASE_W-1] ? W_NEG : W_POS;
			WV_TRI: begin
				if (p4 < 17'd32768)
					wave_d = $signed(p4);
				else if (p4 < 17'd98304)
					wave_d = WAVE_W'(tri_mid);
				else
					wave_d = $signed(p4);
			end
			WV_SAW:    wave_d = $signed({~p16[15], ~p16[15], p16[14:0]});
			default:   wave_d = '0;
		endcase
	end

	// Envelope step decision for the current voice.
	logic signed [17:0] sus_diff;
	logic [MB_W-1:0]    sus_mag;
	env_stage_t         ns_d;
	logic [LEN_W-1:0]   nc_d;
	logic               need_d;
	logic [MB_W-1:0]    mb_d;
	logic [LEN_W-1:0]   den_d;
	lvl_mode_t          mode_d;
	logic [ENV_W-1:0]   fix_d;

	assign sus_diff = $signed({2'b00, sustain_lvl_q}) - 18'sd32768;
	assign sus_mag  = sus_diff[17] ? MB_W'(-sus_diff) : MB_W'(sus_diff);

	always_comb begin
		ns_d   = cur_stage;
		nc_d   = cur_count;
		need_d = 1'b0;
		mb_d   = '0;
		den_d  = attack_len_q;
		mode_d = LV_FIX;
		fix_d  = '0;
		unique case (cur_stage)
			ST_ATTACK: begin
				if (cur_count < attack_len_q) begin
					need_d = 1'b1;
					mb_d   = 17'd32768;
					mode_d = LV_QUO;
					nc_d   = cur_count + 1'b1;
				end else if (decay_len_q != '0) begin
					// Attack ends and the first decay sample is full scale.
					ns_d  = ST_DECAY;
					nc_d  = 20'd1;
					fix_d = 17'd32768;
				end else begin
					ns_d  = ST_SUSTAIN;
					nc_d  = '0;
					fix_d = {1'b0, sustain_lvl_q};
				end
			end
			ST_DECAY: begin
				if (cur_count < decay_len_q) begin
					need_d = 1'b1;
					mb_d   = sus_mag;
					den_d  = decay_len_q;
					mode_d = sus_diff[17] ? LV_DOWN : LV_UP;
					nc_d   = cur_count + 1'b1;
				end else begin
					ns_d  = ST_SUSTAIN;
					fix_d = {1'b0, sustain_lvl_q};
				end
			end
			ST_SUSTAIN: fix_d = {1'b0, sustain_lvl_q};
			ST_RELEASE: begin
				if (cur_count < release_len_q) begin
					need_d = 1'b1;
					mb_d   = {1'b0, sustain_lvl_q};
					den_d  = release_len_q;
					mode_d = LV_REL;
					nc_d   = cur_count + 1'b1;
				end else begin
					ns_d = ST_DONE;
				end
			end
			default: fix_d = '0;
		endcase
	end

	// Arithmetic registers.
	logic signed [V_W-1:0]   v_q;
	logic [EPROD_W-1:0]      eprod_q;
	logic [LEN_W-1:0]        rem_q;
	logic [Q_W-1:0]          quo_q;
	logic [DIV_CNT_W-1:0]    dcnt_q;
	logic [ENV_W-1:0]        lvl_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ACT_W-1:0]        act_q;
	logic signed [MIX_W-1:0] mix_q;
	logic signed [RES_W-1:0] res_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [ACT_W-1:0]        act_out_q;

	logic signed [33:0]       vprod;
	logic signed [35:0]       cprod;
	logic signed [C_W-1:0]    contrib;
	logic signed [21:0]       trial;
	logic signed [MIXP_W-1:0] mixp;
	logic signed [RES_W-1:0]  res_adj;
	logic [ENV_W-1:0]         lvl_d;

	assign vprod   = wave_q * $signed({1'b0, vamp_q});
	assign cprod   = v_q * $signed({1'b0, lvl_q});
	assign contrib = C_W'(cprod >>> 15);
	assign trial   = $signed({1'b0, rem_q, quo_q[Q_W-1]}) - $signed({2'b00, den_q});
	assign mixp    = sum_q * $signed({1'b0, master_gain_q});
	assign res_adj = res_q[RES_W-1] ? (res_q + RES_W'(64'sd1073741823)) : res_q;

	always_comb begin
		unique case (mode_q)
			LV_QUO:  lvl_d = ENV_W'(quo_q);
			LV_UP:   lvl_d = 17'd32768 + ENV_W'(quo_q);
			LV_DOWN: lvl_d = 17'd32768 - ENV_W'(quo_q);
			LV_REL:  lvl_d = ENV_W'(sustain_lvl_q) - ENV_W'(quo_q);
			LV_FIX:  lvl_d = fix_q;
			default: lvl_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.scan) begin
			wave_q <= wave_d;
			vamp_q <= amp_q[idx_q];
			ns_q   <= ns_d;
			nc_q   <= nc_d;
			need_q <= need_d;
			ma_q   <= cur_count;
			mb_q   <= mb_d;
			den_q  <= den_d;
			mode_q <= mode_d;
			fix_q  <= fix_d;
		end
		if (ctl.vmul)
			v_q <= V_W'(vprod >>> 15);
		if (ctl.emul)
			eprod_q <= ma_q * mb_q;
		if (ctl.dinit) begin
			// The quotient is known to fit in Q_W bits, so the top part is below the divisor.
			rem_q <= eprod_q[Q_W +: LEN_W];
			quo_q <= eprod_q[Q_W-1:0];
		end
		if (ctl.dstep) begin
			if (!trial[21])
				rem_q <= trial[LEN_W-1:0];
			else
				rem_q <= {rem_q[LEN_W-2:0], quo_q[Q_W-1]};
			quo_q <= {quo_q[Q_W-2:0], ~trial[21]};
		end
		if (ctl.level)
			lvl_q <= lvl_d;
		if (ctl.mix1) begin
			if (mixp > MIX_HI)
				mix_q <= MIX_W'(MIX_HI);
			else if (mixp < MIX_LO)
				mix_q <= MIX_W'(MIX_LO);
			else
				mix_q <= MIX_W'(mixp);
		end
		if (ctl.mix2)
			res_q <= mix_q * 48'sd32767;
		if (ctl.out_load) begin
			sample_q  <= SAMPLE_W'(res_adj >>> 30);
			act_out_q <= act_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			dcnt_q <= '0;
			sum_q  <= '0;
			act_q  <= '0;
		end else begin
			if (ctl.start_tick) begin
				idx_q <= '0;
				sum_q <= '0;
				act_q <= '0;
			end else if (ctl.next_voice) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ctl.dinit)
				dcnt_q <= '0;
			else if (ctl.dstep)
				dcnt_q <= dcnt_q + 1'b1;
			if (ctl.acc) begin
				sum_q <= sum_q + SUM_W'(contrib);
				if (ns_q != ST_DONE)
					act_q <= act_q + 1'b1;
			end
		end
	end

	assign stat.voice_on   = on_q[idx_q];
	assign stat.last_voice = (idx_q == VI_W'(VOICES - 1));
	assign stat.need_div   = need_q;
	assign stat.div_last   = (dcnt_q == DIV_CNT_W'(Q_W - 1));

	assign sample       = sample_q;
	assign active_count = act_out_q;

endmodule

// ===== sv/polyphonic_adsr_voice_mixer.sv =====
// Top level of the polyphonic tone generator with linear ADSR envelopes.
// A beat on the input channel carries one command. A note-on or note-off beat is taken
// without stalling the input and produces no result. A tick beat produces one result beat
// holding the mixed, clamped 16-bit sample and the number of voices still sounding. The block
// walks its voices one after another through its multipliers and a one-bit-per-cycle restoring
// divider: a silent voice is skipped, a voice at a fixed envelope level is multiplied and
// accumulated, and a voice on an envelope ramp also runs the sixteen divider steps. The input
// stalls from a tick until its result is loaded into the output register. The finished sample
// waits in the output register, so a note command may be taken while it is still being held up.
// Configuration is written through a simple write port and must only change while idle.
module polyphonic_adsr_voice_mixer import pavm_pkg::*; #(
	parameter int VOICES = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CMD_W-1:0]      cmd,
	input  logic [VIDX_W-1:0]     voice_index,
	input  logic [PHASE_W-1:0]    phase_step,
	input  logic [WSEL_W-1:0]     waveform,
	input  logic [AMP_W-1:0]      amplitude,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [SAMPLE_W-1:0] sample,
	output logic [ACT_W-1:0]      active_count,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// Commands from the sequencer and status back from the datapath.
	dp_cmd_t  ctl;
	dp_stat_t stat;

	pavm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.ctl       (ctl),
		.stat      (stat)
	);

	// The datapath holds the voice store, the configuration and all arithmetic.
	pavm_dp #(
		.VOICES (VOICES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cmd          (cmd),
		.voice_index  (voice_index),
		.phase_step   (phase_step),
		.waveform     (waveform),
		.amplitude    (amplitude),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sample       (sample),
		.active_count (active_count)
	);

endmodule

// ===== sv/pavm_checker.sv =====
// Port-level checks of the voice mixer and their binding to the top level.
module pavm_checker import pavm_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_stall,
	input logic [CMD_W-1:0]      cmd,
	input logic                  out_valid,
	input logic                  out_stall,
	input logic signed [SAMPLE_W-1:0] sample,
	input logic [ACT_W-1:0]      active_count
);

	// A held result beat keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(sample) && $stable(active_count))
		else $error("result beat changed while stalled");

	// A tick occupies the block for at least the following cycle.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && cmd == CMD_TICK |=> in_stall)
		else $error("input taken straight after a tick");

	// Note commands never keep the input stalled.
	a_note_quick: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (cmd == CMD_NOTE_ON || cmd == CMD_NOTE_OFF) |=> !in_stall)
		else $error("note command held the input");

	// The clamp keeps the sample off the most negative code.
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample != 16'sh8000)
		else $error("sample outside clamp range");

endmodule

bind polyphonic_adsr_voice_mixer pavm_checker u_pavm_checker (.*);
